[design/button_debounce_setpoint_control_unit_assert.svh]
// Assertion macros used by the top-level design file
`ifndef BUTTON_DEBOUNCE_SETPOINT_CONTROL_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_SETPOINT_CONTROL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BDSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BDSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDSC_ASSERT(lbl, clk, rst, prop, msg)
`define BDSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/bdsc_pkg.sv]
package bdsc_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int BTN_UP      = 0;
   localparam int BTN_DOWN    = 1;
   localparam int BTN_SET     = 2;
   localparam int BTN_VIEW    = 3;

   localparam int THR_W   = 5;
   localparam int SP_W    = 10;
   localparam int WORD_W  = 16;
   localparam int CSR_W   = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(20);
   localparam logic [SP_W-1:0]  RESTORE_LOW_RESET     = SP_W'(535);
   localparam logic [SP_W-1:0]  RESTORE_HIGH_RESET    = SP_W'(746);
   localparam logic [SP_W-1:0]  RESTORE_DEFAULT_RESET = SP_W'(536);
   localparam logic [SP_W-1:0]  SETPOINT_RESET        = SP_W'(535);
   localparam logic [SP_W-1:0]  SETPOINT_MAX          = {SP_W{1'b1}};

   typedef enum logic {
      OP_SCAN    = 1'b0,
      OP_RESTORE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD       = 2'd0,
      CSR_RESTORE_LOW     = 2'd1,
      CSR_RESTORE_HIGH    = 2'd2,
      CSR_RESTORE_DEFAULT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [SP_W-1:0]  restore_low;
      logic [SP_W-1:0]  restore_high;
      logic [SP_W-1:0]  restore_default;
   } cfg_type;

   typedef struct packed {
      logic [SP_W-1:0] setpoint;
      logic            set_mode;
      logic            pressure_view;
      logic            save_request;
      logic            restore_ok;
   } result_type;

endpackage

[design/bdsc_if.sv]
interface bdsc_req_if
   import bdsc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [NUM_BUTTONS-1:0] buttons;
   logic [WORD_W-1:0]      stored_word;

   modport source (output valid, output op, output buttons, output stored_word,
                   input ready);
   modport sink   (input valid, input op, input buttons, input stored_word,
                   output ready);
endinterface

interface bdsc_rsp_if
   import bdsc_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [SP_W-1:0] setpoint;
   logic            set_mode;
   logic            pressure_view;
   logic            save_request;
   logic            restore_ok;

   modport source (output valid, output setpoint, output set_mode, output pressure_view,
                   output save_request, output restore_ok, input ready);
   modport sink   (input valid, input setpoint, input set_mode, input pressure_view,
                   input save_request, input restore_ok, output ready);
endinterface

[design/bdsc_lane.sv]
module bdsc_lane
   import bdsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             scan_en,
   input  logic             pressed,
   input  logic [THR_W-1:0] threshold,
   input  logic             consume,
   output logic             pending
);

   logic [THR_W-1:0] count_ff, count_in;
   logic             held_ff, held_in;
   logic             pend_ff, pend_in;
   logic             arrived;
   logic             arrive;

   assign arrived = (count_ff >= threshold);
   assign arrive  = scan_en && pressed && arrived && !held_ff;
   assign pending = pend_ff || arrive;

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      pend_in  = pending && !consume;
      if (scan_en) begin
         if (!pressed) begin
            count_in = '0;
            held_in  = 1'b0;
         end else if (arrived) begin
            held_in  = 1'b1;
         end else begin
            count_in = count_ff + THR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

[design/bdsc_merge.sv]
module bdsc_merge
   import bdsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   op,
   input  logic [WORD_W-1:0]      stored_word,
   input  cfg_type                cfg,
   input  logic [NUM_BUTTONS-1:0] pending,
   output logic [NUM_BUTTONS-1:0] consume,
   output result_type             result
);

   logic [SP_W-1:0] setpoint_ff, setpoint_in;
   logic            set_mode_ff, set_mode_in;
   logic            view_ff, view_in;
   logic            restore_ff, restore_in;
   logic            scan;
   logic            restore;
   logic            in_range;
   logic [SP_W-1:0] sp_up;
   logic [SP_W-1:0] sp_dn;

   assign scan    = accept && (op_type'(op) == OP_SCAN);
   assign restore = accept && (op_type'(op) == OP_RESTORE);

   assign consume[BTN_UP]   = scan && pending[BTN_UP] && set_mode_ff;
   assign consume[BTN_DOWN] = scan && pending[BTN_DOWN] && set_mode_ff;
   assign consume[BTN_SET]  = scan && pending[BTN_SET];
   assign consume[BTN_VIEW] = scan && pending[BTN_VIEW];

   assign in_range = (stored_word >= WORD_W'(cfg.restore_low)) &&
                     (stored_word <= WORD_W'(cfg.restore_high));

   always_comb begin
      sp_up = setpoint_ff;
      if (consume[BTN_UP] && (setpoint_ff != SETPOINT_MAX)) begin
         sp_up = setpoint_ff + SP_W'(1);
      end
      sp_dn = sp_up;
      if (consume[BTN_DOWN] && (sp_up != '0)) begin
         sp_dn = sp_up - SP_W'(1);
      end
   end

   always_comb begin
      setpoint_in = setpoint_ff;
      restore_in  = restore_ff;
      set_mode_in = set_mode_ff ^ consume[BTN_SET];
      view_in     = view_ff ^ consume[BTN_VIEW];
      priority if (restore) begin
         setpoint_in = in_range ? stored_word[SP_W-1:0] : cfg.restore_default;
         restore_in  = in_range;
      end else if (scan) begin
         setpoint_in = sp_dn;
      end else begin
         setpoint_in = setpoint_ff;
      end
   end

   always_comb begin
      result.setpoint      = setpoint_in;
      result.set_mode      = set_mode_in;
      result.pressure_view = view_in;
      result.save_request  = consume[BTN_SET] && set_mode_ff;
      result.restore_ok    = restore_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         set_mode_ff <= 1'b0;
         view_ff     <= 1'b0;
         restore_ff  <= 1'b0;
      end else begin
         setpoint_ff <= setpoint_in;
         set_mode_ff <= set_mode_in;
         view_ff     <= view_in;
         restore_ff  <= restore_in;
      end
   end

endmodule

[design/button_debounce_setpoint_control_unit.sv]
// Four-button debouncer and heater setpoint control. One item is taken every cycle while
// ready is high; its result is registered into the output buffer. Each button has its
// own debounce lane, and a single merge stage applies the latched pushes and restore
// checks, so all state for an item is updated at acceptance. A two-entry output buffer
// lets the block keep taking items while one result waits; ready drops only when both
// entries are full and during reset. Configuration writes take effect on the next item.
`include "button_debounce_setpoint_control_unit_assert.svh"

module button_debounce_setpoint_control_unit
   import bdsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bdsc_req_if.sink             req_ch,
   bdsc_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type                cfg_ff;
   logic                   accept;
   logic                   pop;
   logic [NUM_BUTTONS-1:0] pending;
   logic [NUM_BUTTONS-1:0] consume;
   result_type             result;
   result_type             out_ff;
   result_type             skid_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold       <= THRESHOLD_RESET;
         cfg_ff.restore_low     <= RESTORE_LOW_RESET;
         cfg_ff.restore_high    <= RESTORE_HIGH_RESET;
         cfg_ff.restore_default <= RESTORE_DEFAULT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD:       cfg_ff.threshold       <= csr_wdata[THR_W-1:0];
            CSR_RESTORE_LOW:     cfg_ff.restore_low     <= csr_wdata[SP_W-1:0];
            CSR_RESTORE_HIGH:    cfg_ff.restore_high    <= csr_wdata[SP_W-1:0];
            CSR_RESTORE_DEFAULT: cfg_ff.restore_default <= csr_wdata[SP_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = !skid_valid_ff && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      bdsc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .scan_en   (accept && (op_type'(req_ch.op) == OP_SCAN)),
         .pressed   (req_ch.buttons[b]),
         .threshold (cfg_ff.threshold),
         .consume   (consume[b]),
         .pending   (pending[b])
      );
   end

   bdsc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_ch.op),
      .stored_word (req_ch.stored_word),
      .cfg         (cfg_ff),
      .pending     (pending),
      .consume     (consume),
      .result      (result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.setpoint      = out_ff.setpoint;
   assign rsp_ch.set_mode      = out_ff.set_mode;
   assign rsp_ch.pressure_view = out_ff.pressure_view;
   assign rsp_ch.save_request  = out_ff.save_request;
   assign rsp_ch.restore_ok    = out_ff.restore_ok;

   `BDSC_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid without output")
   `BDSC_ASSERT(a_accept_fills, clock, reset, accept |=> out_valid_ff, "accepted item lost")
   `BDSC_ASSERT(a_save_leaves_mode, clock, reset, (out_valid_ff && out_ff.save_request) |-> !out_ff.set_mode, "save while in set mode")
   `BDSC_ASSERT(a_consume_only_pending, clock, reset, (consume & ~pending) == '0, "consumed push not pending")

endmodule
